[sv/touch_event_tracker_affine_defines.svh]
// Assertion macros for the touch event tracker.
// Used by the top level; expects clk and rst in scope.
`ifndef TOUCH_EVENT_TRACKER_AFFINE_DEFINES_SVH
`define TOUCH_EVENT_TRACKER_AFFINE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define TETA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TETA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/teta_pkg.sv]
// Shared types and constants for the touch event tracker.
// No dependencies; used by every module of the block.
package teta_pkg;

  localparam int GAIN_W    = 32;
  localparam int DIV_W     = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [GAIN_W-1:0] RST_X_FROM_X = 32'sd8305;
  localparam logic signed [GAIN_W-1:0] RST_X_FROM_Y = -32'sd5;
  localparam logic signed [GAIN_W-1:0] RST_X_OFFSET = -32'sd1442028;
  localparam logic signed [GAIN_W-1:0] RST_Y_FROM_X = -32'sd67;
  localparam logic signed [GAIN_W-1:0] RST_Y_FROM_Y = 32'sd5075;
  localparam logic signed [GAIN_W-1:0] RST_Y_OFFSET = -32'sd1893492;
  localparam logic [DIV_W-1:0]         RST_DIVISOR  = 31'd65536;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DOWN = 2'd1,
    EV_MOVE = 2'd2,
    EV_UP   = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_FROM_X = 3'd0,
    REG_X_FROM_Y = 3'd1,
    REG_X_OFFSET = 3'd2,
    REG_Y_FROM_X = 3'd3,
    REG_Y_FROM_Y = 3'd4,
    REG_Y_OFFSET = 3'd5,
    REG_DIVISOR  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_ABS,
    DIV_CHECK,
    DIV_RUN,
    DIV_FIX
  } div_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DECIDE,
    ST_EMIT
  } seq_state_t;

endpackage

[sv/touch_event_tracker_affine.sv]
// Top level of the touch event tracker: sequencer, calibration registers and event state.
// Depends on teta_pkg, teta_mac, teta_div and touch_event_tracker_affine_defines.svh.
//
// Input transactions arrive on s_axis: tdata carries the raw x and y samples, tuser
// the pen-up flag. Each accepted transaction produces exactly one output transaction
// on m_axis: tuser carries the event code, tdata the corrected x and y position.
// Calibration registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while the block is idle, the block itself does not enforce it.
// An index beyond the divisor is ignored, and a divisor of zero acts as one.
// A pen-up or a dropped first sample goes from acceptance straight to ST_EMIT and
// the output register. A mapped sample runs each coordinate through ST_MUL_A, ST_MUL_B
// and ST_SUM on the shared multiply-accumulate unit, then through the shared
// one-bit-per-cycle divider, which skips its divide steps when the coordinate
// overflows at its range check. s_axis_tready is high only while the sequencer idles.
// A finished result sits in the output register until taken; the next input can be
// accepted meanwhile, and its own result waits for the register to free up.
// Reset is synchronous and restores the default calibration, clears the event state
// and arms the drop of the first sample.
`include "touch_event_tracker_affine_defines.svh"

module touch_event_tracker_affine #(
  parameter int SAMPLE_BITS = 12,
  parameter int COORD_BITS  = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [teta_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [teta_pkg::GAIN_W-1:0]              cfg_data,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // x_sample, y_sample, zero pad
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // pen_up
  input  logic [0:0]                               s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // x_position, y_position, zero pad
  output logic [((2*COORD_BITS+7)/8)*8-1:0]        m_axis_tdata,
  // event_res
  output logic [1:0]                               m_axis_tuser
);

  localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;
  localparam int ACC_W = teta_pkg::GAIN_W + SAMPLE_BITS + 2;

  teta_pkg::seq_state_t state, state_next;

  logic signed [teta_pkg::GAIN_W-1:0] x_from_x, x_from_y, x_offset;
  logic signed [teta_pkg::GAIN_W-1:0] y_from_x, y_from_y, y_offset;
  logic        [teta_pkg::DIV_W-1:0]  divisor;

  logic [SAMPLE_BITS-1:0]       rx, ry;
  logic                         sel;
  logic signed [COORD_BITS-1:0] cx, cy;
  logic signed [COORD_BITS-1:0] last_x, last_y;
  logic signed [COORD_BITS-1:0] report_x, report_y;
  logic                         pen_is_down;
  logic                         skip_next_sample;
  teta_pkg::event_t             report_event;

  logic                         s_accept;
  logic                         pen_up;
  logic                         out_free;
  teta_pkg::mac_ctl_t           mac_ctl;
  logic signed [teta_pkg::GAIN_W-1:0] mac_gain;
  logic [SAMPLE_BITS-1:0]       mac_sample;
  logic signed [teta_pkg::GAIN_W-1:0] mac_offset;
  logic signed [ACC_W-1:0]      acc;
  logic                         div_start;
  logic                         div_done;
  logic signed [COORD_BITS-1:0] div_q;
  logic                         out_load;

  assign s_axis_tready = (state == teta_pkg::ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign pen_up        = s_axis_tuser[0];
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign mac_offset    = sel ? y_offset : x_offset;

  teta_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .gain   (mac_gain),
    .sample (mac_sample),
    .offset (mac_offset),
    .acc    (acc)
  );

  teta_div #(.SAMPLE_BITS(SAMPLE_BITS), .COORD_BITS(COORD_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      teta_pkg::ST_IDLE: begin
        if (s_accept) begin
          state_next = (pen_up || skip_next_sample) ? teta_pkg::ST_EMIT : teta_pkg::ST_MUL_A;
        end
      end
      teta_pkg::ST_MUL_A:  state_next = teta_pkg::ST_MUL_B;
      teta_pkg::ST_MUL_B:  state_next = teta_pkg::ST_SUM;
      teta_pkg::ST_SUM:    state_next = teta_pkg::ST_DIV_GO;
      teta_pkg::ST_DIV_GO: state_next = teta_pkg::ST_DIV_WAIT;
      teta_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = sel ? teta_pkg::ST_DECIDE : teta_pkg::ST_MUL_A;
        end
      end
      teta_pkg::ST_DECIDE: state_next = teta_pkg::ST_EMIT;
      teta_pkg::ST_EMIT:   if (out_free) state_next = teta_pkg::ST_IDLE;
      default:             state_next = teta_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mac_ctl    = '0;
    mac_gain   = sel ? y_from_x : x_from_x;
    mac_sample = rx;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      teta_pkg::ST_MUL_A: begin
        mac_ctl.mul_en = 1'b1;
      end
      teta_pkg::ST_MUL_B: begin
        mac_ctl.mul_en   = 1'b1;
        mac_ctl.acc_load = 1'b1;
        mac_gain         = sel ? y_from_y : x_from_y;
        mac_sample       = ry;
      end
      teta_pkg::ST_SUM:    mac_ctl.acc_add = 1'b1;
      teta_pkg::ST_DIV_GO: div_start = 1'b1;
      teta_pkg::ST_EMIT:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= teta_pkg::ST_IDLE;
      x_from_x         <= teta_pkg::RST_X_FROM_X;
      x_from_y         <= teta_pkg::RST_X_FROM_Y;
      x_offset         <= teta_pkg::RST_X_OFFSET;
      y_from_x         <= teta_pkg::RST_Y_FROM_X;
      y_from_y         <= teta_pkg::RST_Y_FROM_Y;
      y_offset         <= teta_pkg::RST_Y_OFFSET;
      divisor          <= teta_pkg::RST_DIVISOR;
      sel              <= 1'b0;
      last_x           <= '0;
      last_y           <= '0;
      report_x         <= '0;
      report_y         <= '0;
      pen_is_down      <= 1'b0;
      skip_next_sample <= 1'b1;
      report_event     <= teta_pkg::EV_NONE;
      m_axis_tvalid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (teta_pkg::cfg_reg_t'(cfg_index))
          teta_pkg::REG_X_FROM_X: x_from_x <= $signed(cfg_data);
          teta_pkg::REG_X_FROM_Y: x_from_y <= $signed(cfg_data);
          teta_pkg::REG_X_OFFSET: x_offset <= $signed(cfg_data);
          teta_pkg::REG_Y_FROM_X: y_from_x <= $signed(cfg_data);
          teta_pkg::REG_Y_FROM_Y: y_from_y <= $signed(cfg_data);
          teta_pkg::REG_Y_OFFSET: y_offset <= $signed(cfg_data);
          teta_pkg::REG_DIVISOR: begin
            divisor <= (cfg_data[teta_pkg::DIV_W-1:0] == '0) ?
                       teta_pkg::DIV_W'(1) : cfg_data[teta_pkg::DIV_W-1:0];
          end
          default: ;
        endcase
      end

      if (s_accept) begin
        sel <= 1'b0;
        if (pen_up) begin
          report_event     <= pen_is_down ? teta_pkg::EV_UP : teta_pkg::EV_NONE;
          pen_is_down      <= 1'b0;
          skip_next_sample <= 1'b1;
          report_x         <= last_x;
          report_y         <= last_y;
        end else if (skip_next_sample) begin
          skip_next_sample <= 1'b0;
        end
      end

      if (state == teta_pkg::ST_DIV_WAIT && div_done && !sel) begin
        sel <= 1'b1;
      end

      if (state == teta_pkg::ST_DECIDE) begin
        if (!pen_is_down) begin
          pen_is_down  <= 1'b1;
          report_event <= teta_pkg::EV_DOWN;
          report_x     <= cx;
          report_y     <= cy;
        end else if (cx != last_x || cy != last_y) begin
          report_event <= teta_pkg::EV_MOVE;
          report_x     <= cx;
          report_y     <= cy;
        end
        last_x <= cx;
        last_y <= cy;
      end

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      rx <= s_axis_tdata[SAMPLE_BITS-1:0];
      ry <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end
    if (state == teta_pkg::ST_DIV_WAIT && div_done) begin
      if (sel) begin
        cy <= div_q;
      end else begin
        cx <= div_q;
      end
    end
    if (out_load) begin
      m_axis_tdata <= OUT_W'({report_y, report_x});
      m_axis_tuser <= report_event;
    end
  end

  `TETA_ASSERT_NOW(a_div_done_in_wait, div_done, state == teta_pkg::ST_DIV_WAIT, "divider finished outside its wait state")
  `TETA_ASSERT_NEXT(a_pen_up_rearms, s_accept && pen_up, skip_next_sample && !pen_is_down, "pen-up did not re-arm the sample drop")
  `TETA_ASSERT_NOW(a_down_needs_contact, state == teta_pkg::ST_EMIT && report_event == teta_pkg::EV_DOWN, pen_is_down, "down reported without contact")

endmodule

[sv/teta_mac.sv]
// Shared multiply-accumulate unit: one gain times one sample per cycle.
// Depends on teta_pkg for the gain width and the control struct.
module teta_mac #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                             clk,
  input  teta_pkg::mac_ctl_t                               ctl,
  input  logic signed [teta_pkg::GAIN_W-1:0]               gain,
  input  logic        [SAMPLE_BITS-1:0]                    sample,
  input  logic signed [teta_pkg::GAIN_W-1:0]               offset,
  output logic signed [teta_pkg::GAIN_W+SAMPLE_BITS+1:0]   acc
);

  localparam int PROD_W = teta_pkg::GAIN_W + SAMPLE_BITS + 1;
  localparam int ACC_W  = PROD_W + 1;

  logic signed [PROD_W-1:0]    prod;
  logic signed [SAMPLE_BITS:0] samp_s;

  assign samp_s = $signed({1'b0, sample});

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= gain * samp_s;
    end
    if (ctl.acc_load) begin
      acc <= {{(ACC_W-teta_pkg::GAIN_W){offset[teta_pkg::GAIN_W-1]}}, offset}
             + {prod[PROD_W-1], prod};
    end else if (ctl.acc_add) begin
      acc <= acc + {prod[PROD_W-1], prod};
    end
  end

endmodule

[sv/teta_div.sv]
// Iterative signed divider with saturation to a signed coordinate, one quotient bit per cycle.
// Depends on teta_pkg for the divisor width and the state type.
module teta_div #(
  parameter int SAMPLE_BITS = 12,
  parameter int COORD_BITS  = 16
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           start,
  input  logic signed [teta_pkg::GAIN_W+SAMPLE_BITS+1:0] dividend,
  input  logic        [teta_pkg::DIV_W-1:0]              divisor,
  output logic                                           done,
  output logic signed [COORD_BITS-1:0]                   quotient
);

  localparam int ACC_W = teta_pkg::GAIN_W + SAMPLE_BITS + 2;
  localparam int MAG_W = ACC_W - 1;
  localparam int HI_W  = MAG_W - COORD_BITS;
  localparam int CMP_W = (HI_W > teta_pkg::DIV_W) ? HI_W : teta_pkg::DIV_W;
  localparam int CNT_W = $clog2(COORD_BITS + 1);
  localparam logic [COORD_BITS-1:0] POS_LIM = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] NEG_LIM = {1'b1, {(COORD_BITS-1){1'b0}}};

  teta_pkg::div_state_t state, state_next;

  logic [MAG_W-1:0]             mag;
  logic                         neg;
  logic                         ovf;
  logic [teta_pkg::DIV_W-1:0]   rem;
  logic [COORD_BITS-1:0]        low;
  logic [COORD_BITS-1:0]        quo;
  logic [CNT_W-1:0]             cnt;

  logic [ACC_W-1:0]             abs_val;
  logic [CMP_W-1:0]             hi_ext;
  logic                         over;
  logic [teta_pkg::DIV_W:0]     trial;
  logic [teta_pkg::DIV_W:0]     diff;
  logic                         fits;
  logic [COORD_BITS-1:0]        fix_val;
  logic                         ld_abs, ld_check, step, fix;

  assign abs_val = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
  assign hi_ext  = CMP_W'(mag >> COORD_BITS);
  assign over    = hi_ext >= CMP_W'(divisor);
  assign trial   = {rem, low[COORD_BITS-1]};
  assign diff    = trial - {1'b0, divisor};
  assign fits    = trial >= {1'b0, divisor};

  always_comb begin
    if (neg) begin
      fix_val = (ovf || quo > NEG_LIM) ? NEG_LIM : COORD_BITS'(-quo);
    end else begin
      fix_val = (ovf || quo > POS_LIM) ? POS_LIM : quo;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      teta_pkg::DIV_IDLE:  if (start) state_next = teta_pkg::DIV_ABS;
      teta_pkg::DIV_ABS:   state_next = teta_pkg::DIV_CHECK;
      teta_pkg::DIV_CHECK: state_next = over ? teta_pkg::DIV_FIX : teta_pkg::DIV_RUN;
      teta_pkg::DIV_RUN:   if (cnt == CNT_W'(1)) state_next = teta_pkg::DIV_FIX;
      teta_pkg::DIV_FIX:   state_next = teta_pkg::DIV_IDLE;
      default:             state_next = teta_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    ld_abs   = 1'b0;
    ld_check = 1'b0;
    step     = 1'b0;
    fix      = 1'b0;
    unique case (state)
      teta_pkg::DIV_IDLE:  ld_abs   = start;
      teta_pkg::DIV_ABS:   ld_check = 1'b1;
      teta_pkg::DIV_CHECK: ;
      teta_pkg::DIV_RUN:   step     = 1'b1;
      teta_pkg::DIV_FIX:   fix      = 1'b1;
      default:             ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= teta_pkg::DIV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fix;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_abs) begin
      mag <= abs_val[MAG_W-1:0];
      neg <= dividend[ACC_W-1];
    end
    if (ld_check) begin
      ovf <= over;
      rem <= hi_ext[teta_pkg::DIV_W-1:0];
      low <= mag[COORD_BITS-1:0];
      cnt <= CNT_W'(COORD_BITS);
    end else if (step) begin
      rem <= fits ? diff[teta_pkg::DIV_W-1:0] : trial[teta_pkg::DIV_W-1:0];
      low <= low << 1;
      quo <= {quo[COORD_BITS-2:0], fits};
      cnt <= cnt - CNT_W'(1);
    end
    if (fix) begin
      quotient <= $signed(fix_val);
    end
  end

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for touch_event_tracker_affine: a directed table, then random strokes.
// Depends on teta_pkg and the block's RTL; outputs are checked by a local predictor or the table.
`timescale 1ns / 100ps

module testbench;

  localparam int NUM_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int STALL_LIMIT    = 4000;
  localparam logic [teta_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    teta_pkg::event_t   ev;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } report_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [2:0]         idx;
    logic [31:0]        data;
    logic [11:0]        sx;
    logic [11:0]        sy;
    logic               up;
    logic               typed;
    teta_pkg::event_t   ev;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  touch_event_tracker_affine DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  longint  k_xx, k_xy, k_x0, k_yx, k_yy, k_y0, k_div;
  logic signed [15:0] pos_x, pos_y;
  logic    touching, drop_next;
  report_t rep;

  report_t pending_reports[$];
  bit      quiet;
  int      items_sent;
  int      results_seen;
  int      mismatches;
  int      ev_seen[4];
  int      stall_cycles;
  dir_row_t dir_tab [28];

  always #2 clk = ~clk;

  function automatic void reset_tracker();
    k_xx = longint'(teta_pkg::RST_X_FROM_X);
    k_xy = longint'(teta_pkg::RST_X_FROM_Y);
    k_x0 = longint'(teta_pkg::RST_X_OFFSET);
    k_yx = longint'(teta_pkg::RST_Y_FROM_X);
    k_yy = longint'(teta_pkg::RST_Y_FROM_Y);
    k_y0 = longint'(teta_pkg::RST_Y_OFFSET);
    k_div = longint'(teta_pkg::RST_DIVISOR);
    pos_x = '0;
    pos_y = '0;
    touching = 1'b0;
    drop_next = 1'b1;
    rep = '{teta_pkg::EV_NONE, 16'sd0, 16'sd0};
  endfunction

  function automatic void set_register(logic [2:0] idx, logic [31:0] data);
    case (idx)
      teta_pkg::REG_X_FROM_X: k_xx = longint'($signed(data));
      teta_pkg::REG_X_FROM_Y: k_xy = longint'($signed(data));
      teta_pkg::REG_X_OFFSET: k_x0 = longint'($signed(data));
      teta_pkg::REG_Y_FROM_X: k_yx = longint'($signed(data));
      teta_pkg::REG_Y_FROM_Y: k_yy = longint'($signed(data));
      teta_pkg::REG_Y_OFFSET: k_y0 = longint'($signed(data));
      teta_pkg::REG_DIVISOR:  k_div = longint'(data[30:0]);
      default: ;
    endcase
  endfunction

  function automatic logic signed [15:0] calibrate(longint off, longint gx, longint gy,
                                                   longint rx, longint ry);
    longint d;
    longint q;
    d = (k_div == 0) ? 64'sd1 : k_div;
    q = (off + gx * rx + gy * ry) / d;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic report_t track_touch(logic [11:0] sx, logic [11:0] sy, logic up);
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    if (up) begin
      rep.ev = touching ? teta_pkg::EV_UP : teta_pkg::EV_NONE;
      touching = 1'b0;
      drop_next = 1'b1;
      rep.px = pos_x;
      rep.py = pos_y;
    end else if (drop_next) begin
      drop_next = 1'b0;
    end else begin
      cx = calibrate(k_x0, k_xx, k_xy, longint'(sx), longint'(sy));
      cy = calibrate(k_y0, k_yx, k_yy, longint'(sx), longint'(sy));
      if (!touching) begin
        touching = 1'b1;
        rep = '{teta_pkg::EV_DOWN, cx, cy};
      end else if (cx != pos_x || cy != pos_y) begin
        rep = '{teta_pkg::EV_MOVE, cx, cy};
      end
      pos_x = cx;
      pos_y = cy;
    end
    return rep;
  endfunction

  function automatic int nudge(int v);
    int n;
    if ($urandom_range(99) < 10) return $urandom_range(4095);
    n = v + $urandom_range(6) - 3;
    if (n < 0) n = 0;
    if (n > 4095) n = 4095;
    return n;
  endfunction

  function automatic logic [31:0] gain_pm(int lo, int hi);
    int v;
    v = $urandom_range(hi, lo);
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic send_item(input logic [11:0] sx, input logic [11:0] sy, input logic up,
                           input logic typed, input report_t typed_val);
    report_t predicted;
    while (!quiet && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {sy, sx};
    s_axis_tuser <= up;
    do @(posedge clk); while (!s_axis_tready);
    predicted = track_touch(sx, sy, up);
    pending_reports.push_back(typed ? typed_val : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    set_register(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all(input logic [31:0] xx, input logic [31:0] xy, input logic [31:0] x0,
                           input logic [31:0] yx, input logic [31:0] yy, input logic [31:0] y0,
                           input logic [31:0] dv);
    write_reg(teta_pkg::REG_X_FROM_X, xx);
    write_reg(teta_pkg::REG_X_FROM_Y, xy);
    write_reg(teta_pkg::REG_X_OFFSET, x0);
    write_reg(teta_pkg::REG_Y_FROM_X, yx);
    write_reg(teta_pkg::REG_Y_FROM_Y, yy);
    write_reg(teta_pkg::REG_Y_OFFSET, y0);
    write_reg(teta_pkg::REG_DIVISOR, dv);
  endtask

  task automatic program_phase(input int p);
    settle();
    case (p)
      0: write_all(teta_pkg::RST_X_FROM_X, teta_pkg::RST_X_FROM_Y, teta_pkg::RST_X_OFFSET,
                   teta_pkg::RST_Y_FROM_X, teta_pkg::RST_Y_FROM_Y, teta_pkg::RST_Y_OFFSET,
                   {1'b0, teta_pkg::RST_DIVISOR});
      3: begin
        write_reg(REG_UNUSED, $urandom);
        write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      4: write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
      5: write_all(gain_pm(0, 4), 32'd0, gain_pm(0, 50), 32'd0, gain_pm(0, 4),
                   gain_pm(0, 50), $urandom_range(16, 1));
      7: write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 32'h7FFF_FFFF);
      default: write_all(gain_pm(2000, 20000), gain_pm(0, 300), gain_pm(0, 1 << 25),
                         gain_pm(0, 300), gain_pm(2000, 20000), gain_pm(0, 1 << 25),
                         $urandom_range(131072, 4096));
    endcase
  endtask

  task automatic random_stroke();
    int bx;
    int by;
    int n;
    bx = $urandom_range(4095);
    by = $urandom_range(4095);
    n = $urandom_range(30, 2);
    send_item(12'($urandom), 12'($urandom), 1'b1, 1'b0, '0);
    repeat (n) begin
      if ($urandom_range(99) < 70) begin
        bx = nudge(bx);
        by = nudge(by);
      end
      send_item(12'(bx), 12'(by), 1'b0, 1'b0, '0);
    end
  endtask

  task automatic flag_mismatch(input string what, input report_t want, input report_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected ev=%0d x=%0d y=%0d, got ev=%0d x=%0d y=%0d", $time, what,
               want.ev, want.px, want.py, got.ev, got.px, got.py);
  endtask

  always @(negedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.ev = teta_pkg::event_t'(m_axis_tuser);
      got.px = m_axis_tdata[15:0];
      got.py = m_axis_tdata[31:16];
      results_seen++;
      ev_seen[got.ev]++;
      if (pending_reports.size() == 0) begin
        flag_mismatch("result with none expected", '0, got);
      end else begin
        want = pending_reports.pop_front();
        if (want.ev != got.ev || want.px != got.px || want.py != got.py)
          flag_mismatch("wrong result", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    report_t typed_val;
    int phase_end;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = teta_pkg::REG_X_FROM_X;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    quiet = 1'b0;
    items_sent = 0;
    results_seen = 0;
    mismatches = 0;
    stall_cycles = 0;
    ev_seen = '{0, 0, 0, 0};
    reset_tracker();

    dir_tab = '{
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'hFFF, 12'hFFF, 1'b1, 1'b1, teta_pkg::EV_NONE,
        16'sd0, 16'sd0},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'h000, 12'h000, 1'b0, 1'b1, teta_pkg::EV_NONE,
        16'sd0, 16'sd0},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'h000, 12'h000, 1'b0, 1'b1, teta_pkg::EV_DOWN,
        -16'sd22, -16'sd28},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'h000, 12'h000, 1'b0, 1'b1, teta_pkg::EV_DOWN,
        -16'sd22, -16'sd28},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'hFFF, 12'hFFF, 1'b0, 1'b0, teta_pkg::EV_NONE,
        16'sd0, 16'sd0},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'hAAA, 12'h555, 1'b0, 1'b0, teta_pkg::EV_NONE,
        16'sd0, 16'sd0},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'h555, 12'hAAA, 1'b0, 1'b0, teta_pkg::EV_NONE,
        16'sd0, 16'sd0},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'h000, 12'h000, 1'b1, 1'b0, teta_pkg::EV_NONE,
        16'sd0, 16'sd0},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'h000, 12'h000, 1'b1, 1'b0, teta_pkg::EV_NONE,
        16'sd0, 16'sd0},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'h123, 12'h456, 1'b0, 1'b0, teta_pkg::EV_NONE,
        16'sd0, 16'sd0},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'hFFF, 12'h000, 1'b0, 1'b0, teta_pkg::EV_NONE,
        16'sd0, 16'sd0},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'h000, 12'hFFF, 1'b0, 1'b0, teta_pkg::EV_NONE,
        16'sd0, 16'sd0},
      '{ROW_CFG, REG_UNUSED, 32'hFFFF_FFFF, 12'h0, 12'h0, 1'b0, 1'b0, teta_pkg::EV_NONE,
        16'sd0, 16'sd0},
      '{ROW_CFG, teta_pkg::REG_X_FROM_X, 32'h7FFF_FFFF, 12'h0, 12'h0, 1'b0, 1'b0,
        teta_pkg::EV_NONE, 16'sd0, 16'sd0},
      '{ROW_CFG, teta_pkg::REG_X_FROM_Y, 32'h7FFF_FFFF, 12'h0, 12'h0, 1'b0, 1'b0,
        teta_pkg::EV_NONE, 16'sd0, 16'sd0},
      '{ROW_CFG, teta_pkg::REG_X_OFFSET, 32'h7FFF_FFFF, 12'h0, 12'h0, 1'b0, 1'b0,
        teta_pkg::EV_NONE, 16'sd0, 16'sd0},
      '{ROW_CFG, teta_pkg::REG_Y_FROM_X, 32'h8000_0000, 12'h0, 12'h0, 1'b0, 1'b0,
        teta_pkg::EV_NONE, 16'sd0, 16'sd0},
      '{ROW_CFG, teta_pkg::REG_Y_FROM_Y, 32'h8000_0000, 12'h0, 12'h0, 1'b0, 1'b0,
        teta_pkg::EV_NONE, 16'sd0, 16'sd0},
      '{ROW_CFG, teta_pkg::REG_Y_OFFSET, 32'h8000_0000, 12'h0, 12'h0, 1'b0, 1'b0,
        teta_pkg::EV_NONE, 16'sd0, 16'sd0},
      '{ROW_CFG, teta_pkg::REG_DIVISOR, 32'h1, 12'h0, 12'h0, 1'b0, 1'b0,
        teta_pkg::EV_NONE, 16'sd0, 16'sd0},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'hFFF, 12'hFFF, 1'b0, 1'b1, teta_pkg::EV_MOVE,
        16'sd32767, -16'sd32768},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'h000, 12'h000, 1'b0, 1'b1, teta_pkg::EV_MOVE,
        16'sd32767, -16'sd32768},
      '{ROW_CFG, teta_pkg::REG_DIVISOR, 32'h0, 12'h0, 12'h0, 1'b0, 1'b0,
        teta_pkg::EV_NONE, 16'sd0, 16'sd0},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'h001, 12'h001, 1'b0, 1'b1, teta_pkg::EV_MOVE,
        16'sd32767, -16'sd32768},
      '{ROW_CFG, teta_pkg::REG_DIVISOR, 32'hFFFF_FFFF, 12'h0, 12'h0, 1'b0, 1'b0,
        teta_pkg::EV_NONE, 16'sd0, 16'sd0},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'hFFF, 12'hFFF, 1'b0, 1'b1, teta_pkg::EV_MOVE,
        16'sd8191, -16'sd8191},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'h000, 12'h000, 1'b1, 1'b1, teta_pkg::EV_UP,
        16'sd8191, -16'sd8191},
      '{ROW_ITEM, REG_UNUSED, 32'h0, 12'h000, 12'h000, 1'b0, 1'b0, teta_pkg::EV_NONE,
        16'sd0, 16'sd0}
    };

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        typed_val = '{dir_tab[i].ev, dir_tab[i].px, dir_tab[i].py};
        send_item(dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].up, dir_tab[i].typed, typed_val);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      program_phase(p);
      quiet = (p == 2);
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        if ($urandom_range(99) < 85)
          random_stroke();
        else
          send_item(12'($urandom), 12'($urandom), 1'($urandom), 1'b0, '0);
      end
    end
    quiet = 1'b0;

    settle();
    repeat (60) @(negedge clk);
    $display("Sent %0d input transactions: a directed table and %0d calibration settings.",
             items_sent, NUM_PHASES);
    $display("Checked %0d results: %0d none, %0d down, %0d move, %0d up.", results_seen,
             ev_seen[teta_pkg::EV_NONE], ev_seen[teta_pkg::EV_DOWN],
             ev_seen[teta_pkg::EV_MOVE], ev_seen[teta_pkg::EV_UP]);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[touch_event_tracker_affine.f]
+incdir+sv
sv/teta_pkg.sv
sv/teta_mac.sv
sv/teta_div.sv
sv/touch_event_tracker_affine.sv
tb/sv/testbench.sv
